FILE: hdl/hcb_pkg.sv
package hcb_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int WEIGHT_BITS = 24;
    localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W      = $clog2(NODE_DEPTH + 1);
    localparam int SUM_W       = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
    localparam int SYM_W       = 8;
    localparam int IN_WEIGHT_W = 24;
    localparam int LEN_W       = 6;
    localparam int CODE_W      = 63;
    localparam int NODE_MEM_W  = SYM_W + SUM_W;
    localparam int LINK_MEM_W  = NODE_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN1,
        S_SCAN2,
        S_MRG_NEW,
        S_MRG_A,
        S_MRG_B,
        S_EMIT_RD,
        S_EMIT_SYM,
        S_EMIT_WALK
    } state_t;

    typedef struct packed {
        logic              has_parent;
        logic              is_left;
        logic [NODE_W-1:0] parent;
    } link_t;

endpackage

FILE: hdl/huffman_code_builder_core.sv
// huffman code builder
// requests: start with symbol, weight, last while busy is low loads one leaf;
// leaves are numbered by arrival, up to 64 per set, further requests are
// dropped and flag overflow on every code of the set.
// a request with last high raises busy: the block builds the tree and then
// sends one code per leaf in leaf order on out_valid, each for one cycle.
// tree build: every merge runs two scans over all nodes made so far, each
// one node per cycle through the node and link memories, then a drain of
// the last read and a close of the scan; the merge then writes the new node,
// the link of the first pick as left child and of the second as right.
// emit: a read state and a symbol state per leaf, then per code bit one read
// of the link memory following the parent pointer toward the root.
// busy falls in the cycle that shows the last code, which carries last_code.
// reset clears the leaf count, node count and overflow flag and returns to
// idle; memory contents are left as they are and rewritten per set.
// results cannot be held off by the receiver: each code is shown once.
module huffman_code_builder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hcb_pkg::SYM_W-1:0]           symbol,
    input  logic [hcb_pkg::IN_WEIGHT_W-1:0]     weight,
    input  logic                                last,
    output logic                                out_valid,
    output logic [hcb_pkg::SYM_W-1:0]           out_symbol,
    output logic [hcb_pkg::LEN_W-1:0]           code_length,
    output logic [hcb_pkg::CODE_W-1:0]          code_bits,
    output logic                                overflow,
    output logic                                last_code
);
    import hcb_pkg::*;

    localparam logic [SUM_W-1:0] WMASK = SUM_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    state_t state_reg, state_next;
    logic [NODE_W-1:0] lc_reg, lc_next;
    logic [NODE_W-1:0] nc_reg, nc_next;
    logic [NODE_W-1:0] alive_reg, alive_next;
    logic              drop_reg, drop_next;
    logic [NODE_W-1:0] k_reg, k_next;
    logic              pv_reg, pv_next;
    logic [NODE_W-1:0] pidx_reg, pidx_next;
    logic              found_reg, found_next;
    logic [NODE_W-1:0] best_reg, best_next;
    logic [SUM_W-1:0]  bestw_reg, bestw_next;
    logic [NODE_W-1:0] first_reg, first_next;
    logic [SUM_W-1:0]  firstw_reg, firstw_next;
    logic [NODE_W-1:0] i_reg, i_next;
    logic [NODE_W-1:0] p_reg, p_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;

    logic              ov_reg, ov_next;
    logic [SYM_W-1:0]  osym_reg, osym_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic [CODE_W-1:0] ocode_reg, ocode_next;
    logic              oflow_reg, oflow_next;
    logic              olast_reg, olast_next;

    logic                  a_we, a_re, b_we, b_re;
    logic [NODE_W-1:0]     a_waddr, a_raddr, b_waddr, b_raddr;
    logic [NODE_MEM_W-1:0] a_wdata, a_rdata;
    link_t                 b_wdata, b_rdata;
    logic [SUM_W-1:0]      rd_w;
    logic                  cand;

    hcb_ram #(.WIDTH(NODE_MEM_W), .DEPTH(NODE_DEPTH)) u_node_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    hcb_ram #(.WIDTH(LINK_MEM_W), .DEPTH(NODE_DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign rd_w = a_rdata[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lc_reg    <= '0;
            nc_reg    <= '0;
            drop_reg  <= 1'b0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            nc_reg    <= nc_next;
            drop_reg  <= drop_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alive_reg  <= alive_next;
        k_reg      <= k_next;
        pidx_reg   <= pidx_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        bestw_reg  <= bestw_next;
        first_reg  <= first_next;
        firstw_reg <= firstw_next;
        i_reg      <= i_next;
        p_reg      <= p_next;
        len_reg    <= len_next;
        code_reg   <= code_next;
        sym_reg    <= sym_next;
        osym_reg   <= osym_next;
        olen_reg   <= olen_next;
        ocode_reg  <= ocode_next;
        oflow_reg  <= oflow_next;
        olast_reg  <= olast_next;
    end

    // candidate in a scan: node still without parent, and in the second scan not the first pick
    assign cand = !b_rdata.has_parent && ((state_reg == S_SCAN1) || (pidx_reg != first_reg));

    always_comb
    begin
        state_next  = state_reg;
        lc_next     = lc_reg;
        nc_next     = nc_reg;
        alive_next  = alive_reg;
        drop_next   = drop_reg;
        k_next      = k_reg;
        pv_next     = 1'b0;
        pidx_next   = k_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        bestw_next  = bestw_reg;
        first_next  = first_reg;
        firstw_next = firstw_reg;
        i_next      = i_reg;
        p_next      = p_reg;
        len_next    = len_reg;
        code_next   = code_reg;
        sym_next    = sym_reg;
        ov_next     = 1'b0;
        osym_next   = osym_reg;
        olen_next   = olen_reg;
        ocode_next  = ocode_reg;
        oflow_next  = oflow_reg;
        olast_next  = olast_reg;
        a_we        = 1'b0;
        a_waddr     = nc_reg;
        a_wdata     = {SYM_W'(0), SUM_W'(firstw_reg + bestw_reg)};
        a_re        = 1'b0;
        a_raddr     = k_reg;
        b_we        = 1'b0;
        b_waddr     = nc_reg;
        b_wdata     = '0;
        b_re        = 1'b0;
        b_raddr     = k_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (lc_reg < NODE_W'(MAX_SYMBOLS))
                    begin
                        a_we    = 1'b1;
                        a_waddr = lc_reg;
                        a_wdata = {symbol, SUM_W'(weight) & WMASK};
                        b_we    = 1'b1;
                        b_waddr = lc_reg;
                        lc_next = lc_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (last)
                    begin
                        nc_next    = lc_next;
                        alive_next = lc_next;
                        k_next     = '0;
                        found_next = 1'b0;
                        i_next     = '0;
                        state_next = (lc_next > NODE_W'(1)) ? S_SCAN1 : S_EMIT_RD;
                    end
                end
            end

            S_SCAN1, S_SCAN2:
            begin
                if (k_reg != nc_reg)
                begin
                    a_re    = 1'b1;
                    b_re    = 1'b1;
                    pv_next = 1'b1;
                    k_next  = k_reg + 1'b1;
                end
                if (pv_reg && cand && (!found_reg || rd_w < bestw_reg))
                begin
                    found_next = 1'b1;
                    best_next  = pidx_reg;
                    bestw_next = rd_w;
                end
                if (k_reg == nc_reg && !pv_reg)
                begin
                    k_next     = '0;
                    found_next = 1'b0;
                    if (state_reg == S_SCAN1)
                    begin
                        first_next  = best_reg;
                        firstw_next = bestw_reg;
                        state_next  = S_SCAN2;
                    end
                    else
                    begin
                        state_next = S_MRG_NEW;
                    end
                end
            end

            S_MRG_NEW:
            begin
                a_we       = 1'b1;
                b_we       = 1'b1;
                state_next = S_MRG_A;
            end

            S_MRG_A:
            begin
                b_we       = 1'b1;
                b_waddr    = first_reg;
                b_wdata    = '{has_parent: 1'b1, is_left: 1'b1, parent: nc_reg};
                state_next = S_MRG_B;
            end

            S_MRG_B:
            begin
                b_we       = 1'b1;
                b_waddr    = best_reg;
                b_wdata    = '{has_parent: 1'b1, is_left: 1'b0, parent: nc_reg};
                nc_next    = nc_reg + 1'b1;
                alive_next = alive_reg - 1'b1;
                state_next = (alive_reg > NODE_W'(2)) ? S_SCAN1 : S_EMIT_RD;
            end

            S_EMIT_RD:
            begin
                a_re       = 1'b1;
                a_raddr    = i_reg;
                b_re       = 1'b1;
                b_raddr    = i_reg;
                p_next     = i_reg;
                len_next   = '0;
                code_next  = '0;
                state_next = S_EMIT_SYM;
            end

            S_EMIT_SYM:
            begin
                sym_next   = a_rdata[NODE_MEM_W-1:SUM_W];
                state_next = S_EMIT_WALK;
            end

            S_EMIT_WALK:
            begin
                if (p_reg == nc_reg - 1'b1)
                begin
                    ov_next    = 1'b1;
                    osym_next  = sym_reg;
                    olen_next  = len_reg;
                    ocode_next = code_reg;
                    oflow_next = drop_reg;
                    olast_next = (i_reg + 1'b1 == lc_reg);
                    i_next     = i_reg + 1'b1;
                    if (i_reg + 1'b1 == lc_reg)
                    begin
                        lc_next    = '0;
                        nc_next    = '0;
                        drop_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
                else
                begin
                    // follow the parent pointer straight from the read data
                    if (!b_rdata.is_left)
                    begin
                        code_next = code_reg | (CODE_W'(1) << len_reg);
                    end
                    len_next = len_reg + 1'b1;
                    p_next   = b_rdata.parent;
                    b_re     = 1'b1;
                    b_raddr  = b_rdata.parent;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign out_symbol  = osym_reg;
    assign code_length = olen_reg;
    assign code_bits   = ocode_reg;
    assign overflow    = oflow_reg;
    assign last_code   = olast_reg;

endmodule

FILE: hdl/hcb_ram.sv
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
